### hdl/mrfcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mrfcc_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned CRC_W   = 16;
	localparam int unsigned LEN_W   = 8;

	// register indexes on the configuration port
	localparam logic CFG_MAX_LEN = 1'b0;
	localparam logic CFG_SKIP_CR = 1'b1;

	localparam logic [BYTE_W-1:0] MAX_LEN_RST = 8'd10;
	localparam logic              SKIP_CR_RST = 1'b1;

	localparam logic [BYTE_W-1:0] CR_BYTE     = 8'h0D;
	localparam logic [LEN_W:0]    CHECK_ABOVE = 9'd4;
	localparam logic [CRC_W-1:0]  CRC_INIT    = 16'hFFFF;
	localparam logic [CRC_W-1:0]  CRC_POLY    = 16'hA001;

	// one result beat
	typedef struct packed {
		logic             good;
		logic             dropped;
		logic [LEN_W-1:0] length;
	} result_t;

	// Modbus CRC-16, one byte folded in (reflected, LSB first)
	function automatic logic [CRC_W-1:0] crc_add_byte(
		input logic [CRC_W-1:0]  crc_in,
		input logic [BYTE_W-1:0] data
	);
		logic [CRC_W-1:0] c;
		c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data};
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

### hdl/mrfcc_in_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module mrfcc_in_reg
	import mrfcc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [BYTE_W-1:0] rx_byte,
	input  wire logic              advance,
	output logic                   valid_s1,
	output logic [BYTE_W-1:0]      byte_s1
);

	logic take;

	// hold off only while a beat sits here and cannot move on
	assign in_stall = valid_s1 & ~advance;
	assign take     = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take | (valid_s1 & ~advance);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

`default_nettype wire

### hdl/mrfcc_check.sv
`timescale 1ns / 1ps
`default_nettype none

module mrfcc_check
	import mrfcc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              advance,
	input  wire logic [BYTE_W-1:0] byte_s1,
	input  wire logic [BYTE_W-1:0] max_len,
	input  wire logic              skip_cr,
	output result_t                res
);

	logic [LEN_W-1:0]  count_q;
	logic [CRC_W-1:0]  crc_q;
	logic [BYTE_W-1:0] older_q;
	logic [BYTE_W-1:0] newer_q;

	logic              skip;
	logic [CRC_W-1:0]  crc_adv;
	logic [LEN_W:0]    next;
	logic [LEN_W-1:0]  next_sat;
	logic              checking;
	logic              match;
	logic              drop;

	// frame decision for the byte in the input register
	always_comb begin
		skip     = skip_cr & (byte_s1 == CR_BYTE);
		crc_adv  = (count_q >= LEN_W'(2)) ? crc_add_byte(crc_q, older_q) : crc_q;
		next     = {1'b0, count_q} + (LEN_W+1)'(1);
		next_sat = next[LEN_W] ? {LEN_W{1'b1}} : next[LEN_W-1:0];
		checking = next > CHECK_ABOVE;
		match    = checking & ({byte_s1, newer_q} == crc_adv);
		drop     = checking & ~match & (next > {1'b0, max_len});

		res.good    = 1'b0;
		res.dropped = 1'b0;
		res.length  = count_q;
		if (!skip) begin
			res.good    = match;
			res.dropped = drop;
			res.length  = next_sat;
		end
	end

	// candidate frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			crc_q   <= CRC_INIT;
			older_q <= '0;
			newer_q <= '0;
		end else if (advance && !skip) begin
			if (match || drop) begin
				count_q <= '0;
				crc_q   <= CRC_INIT;
				older_q <= '0;
				newer_q <= '0;
			end else begin
				count_q <= next[LEN_W-1:0];
				crc_q   <= crc_adv;
				older_q <= newer_q;
				newer_q <= byte_s1;
			end
		end
	end

	// checks
	a_good_xor_drop: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> !(res.good && res.dropped))
		else $error("good and dropped in one beat");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (res.good || res.dropped) |=> count_q == '0 && crc_q == CRC_INIT)
		else $error("frame did not restart");

	a_skip_hold: assert property (@(posedge clk) disable iff (!arst_n)
		advance && skip |=> $stable(count_q) && $stable(crc_q) && $stable(newer_q))
		else $error("skipped byte changed frame state");

endmodule

`default_nettype wire

### hdl/mrfcc_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module mrfcc_out_reg
	import mrfcc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             advance,
	input  result_t               res,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic                  frame_good,
	output logic                  frame_dropped,
	output logic [LEN_W-1:0]      frame_length
);

	result_t res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign frame_good    = res_s2.good;
	assign frame_dropped = res_s2.dropped;
	assign frame_length  = res_s2.length;

endmodule

`default_nettype wire

### hdl/modbus_rtu_frame_crc_checker_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// channel | signals                                        | dir
// --------+------------------------------------------------+----
// in      | in_valid, in_stall, rx_byte                    | in
// out     | out_valid, out_stall, frame_good,              | out
//         | frame_dropped, frame_length                    |
// cfg     | cfg_we, cfg_index, cfg_data                    | in
//
// One beat per cycle sustained while out_stall is low; each beat passes from the input register to the result register.
// The byte-wide CRC update and frame compare sit between those two registers.
// Reset: frame state cleared, CRC 0xFFFF, max_len 10, skip_cr 1.
// A stalled result holds; one more beat waits in the input register, then in_stall rises.

module modbus_rtu_frame_crc_checker_unit
	import mrfcc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [BYTE_W-1:0] rx_byte,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   frame_good,
	output logic                   frame_dropped,
	output logic [LEN_W-1:0]       frame_length,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [BYTE_W-1:0] cfg_data
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              advance;
	result_t           res;
	logic [BYTE_W-1:0] max_len_q;
	logic              skip_cr_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RST;
			skip_cr_q <= SKIP_CR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAX_LEN: max_len_q <= cfg_data;
				CFG_SKIP_CR: skip_cr_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// beat moves into the result register when it is free or draining
	assign advance = valid_s1 & (~out_valid | ~out_stall);

	mrfcc_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	mrfcc_check u_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.byte_s1 (byte_s1),
		.max_len (max_len_q),
		.skip_cr (skip_cr_q),
		.res     (res)
	);

	mrfcc_out_reg u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.res           (res),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.frame_good    (frame_good),
		.frame_dropped (frame_dropped),
		.frame_length  (frame_length)
	);

endmodule

`default_nettype wire
